/* hdl/wme_pkg.sv */
package wme_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int LEN_BITS   = 24;

	// ring address and count widths follow from the largest window
	localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	localparam int WS_W   = 7;
	localparam int LIM_W  = 7;
	localparam int RUN_W  = 8;
	localparam int BASE_W = 3;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
	localparam logic [RUN_W-1:0]    RUN_MAX = '1;

	localparam logic [WS_W-1:0]  RST_WINDOW_SIZE    = WS_W'(16);
	localparam logic [LIM_W-1:0] RST_MISMATCH_LIMIT = LIM_W'(7);
	localparam logic [RUN_W-1:0] RST_MIN_RUN        = RUN_W'(3);

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_WINDOW_SIZE    = 2'd0;
	localparam logic [1:0] REG_MISMATCH_LIMIT = 2'd1;
	localparam logic [1:0] REG_MIN_RUN        = 2'd2;

endpackage

/* hdl/windowed_mismatch_extension_top.sv */
// Windowed mismatch extension. Feed the symbol pairs of one extension attempt, the first one
// flagged start_attempt; the block counts mismatches (an N symbol always mismatches) over the
// last window_size pairs and tracks runs of matches. When the window count exceeds
// mismatch_limit, or at the pair flagged last_pair, one result comes out: the length up to the
// end of the last qualifying match run and whether the limit ended the attempt. Pairs after
// that are dropped until the next start. Throughput is one pair per clock cycle, set by the
// single read-modify-write of the 64 x 1 mismatch ring memory: the ring bit is read at the
// edge a pair is accepted and written back when that pair leaves stage 1, with a forwarding path for a
// back-to-back pair hitting the same entry (window size 1). A result lands in the output
// register when its pair leaves stage 1. The input stalls only while a result waits
// in the output register under out_stall and the next result is ready behind it. The ring
// has per-entry valid bits that a start clears all at once, so there is no clearing
// pass after reset. Registers sit at byte addresses 0 (window_size), 4 (mismatch_limit) and
// 8 (min_run); write them only while the block is idle.
module windowed_mismatch_extension_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [wme_pkg::ADDR_W-1:0]     paddr,
	input  logic [wme_pkg::DATA_W-1:0]     pwdata,
	output logic [wme_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	// pair input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [wme_pkg::BASE_W-1:0]     data_base,
	input  logic [wme_pkg::BASE_W-1:0]     ref_base,
	input  logic                           start_attempt,
	input  logic                           last_pair,
	// result output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [wme_pkg::LEN_BITS-1:0]   extension_len,
	output logic                           stopped_by_mismatches
);

	localparam int PTR_W = wme_pkg::PTR_W;
	localparam int CNT_W = wme_pkg::CNT_W;
	localparam int LEN_W = wme_pkg::LEN_BITS;
	localparam int RUN_W = wme_pkg::RUN_W;

	// ---------------------------------------------------------------- configuration
	logic [wme_pkg::WS_W-1:0]  window_size_q;
	logic [wme_pkg::LIM_W-1:0] mismatch_limit_q;
	logic [RUN_W-1:0]          min_run_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q    <= wme_pkg::RST_WINDOW_SIZE;
			mismatch_limit_q <= wme_pkg::RST_MISMATCH_LIMIT;
			min_run_q        <= wme_pkg::RST_MIN_RUN;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				wme_pkg::REG_WINDOW_SIZE:    window_size_q    <= pwdata[wme_pkg::WS_W-1:0];
				wme_pkg::REG_MISMATCH_LIMIT: mismatch_limit_q <= pwdata[wme_pkg::LIM_W-1:0];
				wme_pkg::REG_MIN_RUN:        min_run_q        <= pwdata[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			wme_pkg::REG_WINDOW_SIZE:    prdata = wme_pkg::DATA_W'(window_size_q);
			wme_pkg::REG_MISMATCH_LIMIT: prdata = wme_pkg::DATA_W'(mismatch_limit_q);
			wme_pkg::REG_MIN_RUN:        prdata = wme_pkg::DATA_W'(min_run_q);
			default:                     prdata = '0;
		endcase
	end

	// Clamp the window: zero acts as one, anything above the ring depth as the depth.
	logic [CNT_W-1:0] ws_eff;

	always_comb begin
		if (window_size_q == '0)
			ws_eff = CNT_W'(1);
		else if (int'(window_size_q) > wme_pkg::WINDOW_MAX)
			ws_eff = CNT_W'(wme_pkg::WINDOW_MAX);
		else
			ws_eff = CNT_W'(window_size_q);
	end

	// ---------------------------------------------------------------- state
	logic                  ring_mem [wme_pkg::WINDOW_MAX];
	logic [wme_pkg::WINDOW_MAX-1:0] ring_vld_q;
	logic [PTR_W-1:0]      ptr_q;
	logic                  act_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [RUN_W-1:0]      run_q;
	logic [LEN_W-1:0]      pos_q;
	logic [LEN_W-1:0]      best_q;

	// stage 1: the pair whose ring bit is being read back
	logic                  v_s1;
	logic                  start_s1;
	logic                  last_s1;
	logic                  miss_s1;
	logic [PTR_W-1:0]      addr_s1;
	logic                  rd_s1;
	logic                  vld_s1;
	logic                  fwdv_s1;
	logic                  fbit_s1;

	logic                  out_valid_q;
	logic [LEN_W-1:0]      out_len_q;
	logic                  out_stop_q;

	// ---------------------------------------------------------------- stage 1 update
	logic [CNT_W-1:0]      cnt_base, cnt_new;
	logic [RUN_W-1:0]      run_base, run_new;
	logic [LEN_W-1:0]      pos_base, pos_new, best_base, best_new;
	logic                  old_bit;
	logic                  over_s1;
	logic                  stop_s1;
	logic                  s1_go;
	logic                  hold;

	always_comb begin
		cnt_base  = start_s1 ? '0 : cnt_q;
		run_base  = start_s1 ? min_run_q : run_q;
		pos_base  = start_s1 ? '0 : pos_q;
		best_base = start_s1 ? '0 : best_q;

		// bit leaving the slot: forwarded from the pair just written, else memory if valid
		old_bit = fwdv_s1 ? fbit_s1 : (vld_s1 & rd_s1);
		cnt_new = cnt_base + CNT_W'(miss_s1) - CNT_W'(old_bit);

		pos_new  = (pos_base == wme_pkg::LEN_MAX) ? pos_base : pos_base + LEN_W'(1);
		best_new = best_base;
		if (miss_s1) begin
			run_new = '0;
		end else begin
			run_new = (run_base == wme_pkg::RUN_MAX) ? run_base : run_base + RUN_W'(1);
			if (run_new >= min_run_q)
				best_new = pos_new;
		end

		over_s1 = int'(cnt_new) > int'(mismatch_limit_q);
		stop_s1 = over_s1 | last_s1;
	end

	// Hold stage 1 only when it has a result and the output register cannot take it.
	assign s1_go    = v_s1 & (!stop_s1 | !out_valid_q | !out_stall);
	assign hold     = v_s1 & !s1_go;
	assign in_stall = hold;

	// ---------------------------------------------------------------- accept side
	logic                  accept;
	logic                  act_eff;
	logic                  proc;
	logic                  miss_in;
	logic [PTR_W-1:0]      ptr_base, addr_in, ptr_next;
	logic [CNT_W-1:0]      addr_inc;

	always_comb begin
		accept  = in_valid & !in_stall;
		// an attempt that ends in stage 1 this cycle no longer takes pairs
		act_eff = act_q & !(v_s1 & stop_s1);
		proc    = accept & (start_attempt | act_eff);
		miss_in = !((data_base == ref_base) && !data_base[2]);

		ptr_base = start_attempt ? '0 : ptr_q;
		addr_in  = (CNT_W'(ptr_base) >= ws_eff) ? '0 : ptr_base;
		addr_inc = CNT_W'(addr_in) + CNT_W'(1);
		ptr_next = (addr_inc >= ws_eff) ? '0 : addr_inc[PTR_W-1:0];
	end

	// ---------------------------------------------------------------- ring memory
	always_ff @(posedge clk) begin
		if (s1_go)
			ring_mem[addr_s1] <= miss_s1;
	end

	always_ff @(posedge clk) begin
		if (proc)
			rd_s1 <= ring_mem[addr_in];
	end

	// A start wipes the valid bits; the write of the pair ahead of it belongs to the old attempt.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ring_vld_q <= '0;
		else if (proc && start_attempt)
			ring_vld_q <= '0;
		else if (s1_go)
			ring_vld_q[addr_s1] <= 1'b1;
	end

	// ---------------------------------------------------------------- pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			act_q <= 1'b0;
			ptr_q <= '0;
		end else begin
			if (!hold)
				v_s1 <= proc;
			if (proc && start_attempt)
				act_q <= 1'b1;
			else if (s1_go && stop_s1)
				act_q <= 1'b0;
			if (proc)
				ptr_q <= ptr_next;
		end
	end

	// stage 1 payload: advance with each processed pair
	always_ff @(posedge clk) begin
		if (proc) begin
			start_s1 <= start_attempt;
			last_s1  <= last_pair;
			miss_s1  <= miss_in;
			addr_s1  <= addr_in;
			vld_s1   <= !start_attempt & ring_vld_q[addr_in];
			// the pair in stage 1 writes this entry at the same edge as the read
			fwdv_s1  <= !start_attempt & s1_go & (addr_s1 == addr_in);
			fbit_s1  <= miss_s1;
		end
	end

	// attempt counters: commit when stage 1 advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= wme_pkg::RST_MIN_RUN;
			pos_q  <= '0;
			best_q <= '0;
		end else if (s1_go) begin
			cnt_q  <= cnt_new;
			run_q  <= run_new;
			pos_q  <= pos_new;
			best_q <= best_new;
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_go && stop_s1)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go && stop_s1) begin
			out_len_q  <= best_new;
			out_stop_q <= over_s1;
		end
	end

	assign out_valid             = out_valid_q;
	assign extension_len         = out_len_q;
	assign stopped_by_mismatches = out_stop_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= wme_pkg::WINDOW_MAX)
		else $error("mismatch count above ring depth");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && stop_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && stop_s1) |=> out_valid)
		else $error("finished attempt did not reach the output register");

	a_end_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && stop_s1 && !(proc && start_attempt)) |=> !act_q)
		else $error("attempt still active after its result");
`endif

endmodule

/* sim/windowed_mismatch_extension_checker.sv */
`timescale 1ns / 1ps

module windowed_mismatch_extension_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wme_pkg::ADDR_W-1:0]   paddr,
	input  logic [wme_pkg::DATA_W-1:0]   pwdata,
	input  logic                         pready,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [wme_pkg::BASE_W-1:0]   data_base,
	input  logic [wme_pkg::BASE_W-1:0]   ref_base,
	input  logic                         start_attempt,
	input  logic                         last_pair,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [wme_pkg::LEN_BITS-1:0] extension_len,
	input  logic                         stopped_by_mismatches,
	output int                           mismatches,
	output int                           results_due
);

	typedef struct packed {
		logic [wme_pkg::LEN_BITS-1:0] len;
		logic                         stop;
	} ext_result_t;

	// register copies
	logic [wme_pkg::WS_W-1:0]  cfg_window;
	logic [wme_pkg::LIM_W-1:0] cfg_limit;
	logic [wme_pkg::RUN_W-1:0] cfg_min_run;

	// attempt state
	logic [wme_pkg::WINDOW_MAX-1:0] miss_ring;
	logic [wme_pkg::PTR_W-1:0]      ring_ptr;
	logic [wme_pkg::CNT_W-1:0]      miss_cnt;
	logic [wme_pkg::RUN_W-1:0]      match_run;
	logic [wme_pkg::LEN_BITS-1:0]   pos;
	logic [wme_pkg::LEN_BITS-1:0]   best;
	logic                           active;

	ext_result_t ext_due[$];
	ext_result_t want;
	ext_result_t fresh;
	logic        emit;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// advance the attempt by one pair; emit flags a result
	function automatic void extend_pair(input logic [wme_pkg::BASE_W-1:0] d,
			input logic [wme_pkg::BASE_W-1:0] r,
			input logic st, input logic lst, output logic emit_o, output ext_result_t res);
		int   ws;
		logic miss;
		emit_o = 1'b0;
		res = '0;
		if (cfg_window == '0)
			ws = 1;
		else if (cfg_window > wme_pkg::WINDOW_MAX)
			ws = wme_pkg::WINDOW_MAX;
		else
			ws = int'(cfg_window);
		if (st) begin
			miss_ring = '0;
			ring_ptr = '0;
			miss_cnt = '0;
			match_run = cfg_min_run;
			pos = '0;
			best = '0;
			active = 1'b1;
		end
		if (!active)
			return;
		// N codes never match
		miss = !(d == r && d < 4);
		if (int'(ring_ptr) >= ws)
			ring_ptr = '0;
		miss_cnt = miss_cnt - wme_pkg::CNT_W'(miss_ring[ring_ptr]) + wme_pkg::CNT_W'(miss);
		miss_ring[ring_ptr] = miss;
		ring_ptr = (int'(ring_ptr) + 1 >= ws) ? '0 : ring_ptr + 1'b1;
		if (!miss) begin
			if (match_run < wme_pkg::RUN_MAX)
				match_run = match_run + 1'b1;
			if (match_run >= cfg_min_run)
				best = (pos < wme_pkg::LEN_MAX) ? pos + 1'b1 : wme_pkg::LEN_MAX;
		end else begin
			match_run = '0;
		end
		if (pos < wme_pkg::LEN_MAX)
			pos = pos + 1'b1;
		if (miss_cnt > cfg_limit || lst) begin
			emit_o = 1'b1;
			res.len = best;
			res.stop = (miss_cnt > cfg_limit);
			active = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_window = wme_pkg::RST_WINDOW_SIZE;
			cfg_limit = wme_pkg::RST_MISMATCH_LIMIT;
			cfg_min_run = wme_pkg::RST_MIN_RUN;
			miss_ring = '0;
			ring_ptr = '0;
			miss_cnt = '0;
			match_run = wme_pkg::RST_MIN_RUN;
			pos = '0;
			best = '0;
			active = 1'b0;
			ext_due.delete();
			mismatches = 0;
			results_due <= 0;
		end else begin
			// compare the result leaving the block against the oldest prediction
			if (out_valid && !out_stall) begin
				if (ext_due.size() == 0) begin
					report_mismatch($sformatf("result len %0d stop %0b with none expected",
						extension_len, stopped_by_mismatches));
				end else begin
					want = ext_due.pop_front();
					if (extension_len !== want.len)
						report_mismatch($sformatf("extension_len %0d, expected %0d",
							extension_len, want.len));
					if (stopped_by_mismatches !== want.stop)
						report_mismatch($sformatf("stopped_by_mismatches %0b, expected %0b",
							stopped_by_mismatches, want.stop));
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					wme_pkg::REG_WINDOW_SIZE:    cfg_window = pwdata[wme_pkg::WS_W-1:0];
					wme_pkg::REG_MISMATCH_LIMIT: cfg_limit = pwdata[wme_pkg::LIM_W-1:0];
					wme_pkg::REG_MIN_RUN:        cfg_min_run = pwdata[wme_pkg::RUN_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				extend_pair(data_base, ref_base, start_attempt, last_pair, emit, fresh);
				if (emit)
					ext_due.insert(ext_due.size(), fresh);
			end
			results_due <= ext_due.size();
		end
	end

endmodule

/* sim/windowed_mismatch_extension_top_tb.sv */
`timescale 1ns / 1ps

module windowed_mismatch_extension_top_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_LEN    = 200;
	localparam int N_SETS      = 11;
	localparam int PHASE_ITEMS = 20;

	// fixed register settings first, extremes among them; later phases draw at random
	int set_ws  [8] = '{1, 64, 0, 127, 2, 8, 5, 33};
	int set_lim [8] = '{0, 64, 2, 127, 1, 3, 0, 10};
	int set_run [8] = '{0, 255, 1, 0, 5, 2, 255, 4};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [wme_pkg::ADDR_W-1:0]   paddr = '0;
	logic [wme_pkg::DATA_W-1:0]   pwdata = '0;
	logic [wme_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [wme_pkg::BASE_W-1:0]   data_base = '0;
	logic [wme_pkg::BASE_W-1:0]   ref_base = '0;
	logic                         start_attempt = 1'b0;
	logic                         last_pair = 1'b0;

	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [wme_pkg::LEN_BITS-1:0] extension_len;
	logic                         stopped_by_mismatches;

	int mismatches;
	int results_due;
	int cycle_count = 0;

	// random idling on both sides while set
	bit gaps_on = 1'b1;
	// asks the receiver for one long hold-off
	bit hold_req = 1'b0;

	always #5 clk = ~clk;

	windowed_mismatch_extension_top DUT (
		.clk                   (clk),
		.arst_n                (arst_n),
		.psel                  (psel),
		.penable               (penable),
		.pwrite                (pwrite),
		.paddr                 (paddr),
		.pwdata                (pwdata),
		.prdata                (prdata),
		.pready                (pready),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.data_base             (data_base),
		.ref_base              (ref_base),
		.start_attempt         (start_attempt),
		.last_pair             (last_pair),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.extension_len         (extension_len),
		.stopped_by_mismatches (stopped_by_mismatches)
	);

	windowed_mismatch_extension_checker ext_check (
		.clk                   (clk),
		.arst_n                (arst_n),
		.psel                  (psel),
		.penable               (penable),
		.pwrite                (pwrite),
		.paddr                 (paddr),
		.pwdata                (pwdata),
		.pready                (pready),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.data_base             (data_base),
		.ref_base              (ref_base),
		.start_attempt         (start_attempt),
		.last_pair             (last_pair),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.extension_len         (extension_len),
		.stopped_by_mismatches (stopped_by_mismatches),
		.mismatches            (mismatches),
		.results_due           (results_due)
	);

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver: stall at random, or, when asked, hold off once for a stretch set by HOLD_LEN so that
	// results pile up inside the block and it has to stall its input.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				out_stall <= gaps_on && ($urandom_range(99) < 30);
				@(posedge clk);
			end
		end
	end

	// Offer one pair and hold it until the block takes it. Idle first at random;
	// valid stays high from one item to the next when no gap is drawn.
	task automatic send_pair(input logic [wme_pkg::BASE_W-1:0] d,
			input logic [wme_pkg::BASE_W-1:0] r, input logic st, input logic lst);
		while (gaps_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_base <= d;
		ref_base <= r;
		start_attempt <= st;
		last_pair <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// One well-formed attempt: start on the first pair, last on the final one.
	// match_pct sets how often the pair is a clean match; miss_at forces an N
	// symbol at that index (-1 for none).
	task automatic run_attempt(input int n, input int match_pct, input int miss_at);
		logic [wme_pkg::BASE_W-1:0] d;
		logic [wme_pkg::BASE_W-1:0] r;
		for (int k = 0; k < n; k++) begin
			if (k == miss_at) begin
				d = wme_pkg::BASE_W'($urandom_range(7, 4));
				r = wme_pkg::BASE_W'($urandom_range(7));
			end else if ($urandom_range(99) < match_pct) begin
				d = wme_pkg::BASE_W'($urandom_range(3));
				r = d;
			end else begin
				d = wme_pkg::BASE_W'($urandom_range(7));
				r = wme_pkg::BASE_W'($urandom_range(7));
			end
			send_pair(d, r, k == 0, k == n - 1);
		end
	endtask

	// Drop valid and wait until every predicted result has come out, then let the
	// block settle before touching its registers.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; junk in the unused upper bits.
	task automatic write_reg(input logic [1:0] idx, input int value, input int w);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= (($urandom() >> w) << w) | wme_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_phase(input int n_items);
		int sent;
		int n;
		sent = 0;
		// finish whatever attempt the register write landed in
		for (int k = 0; k < 3; k++)
			send_pair(wme_pkg::BASE_W'($urandom_range(3)), wme_pkg::BASE_W'($urandom_range(3)),
				1'b0, k == 2);
		while (sent < n_items) begin
			if ($urandom_range(99) < 10) begin
				// noise: stray pairs, stray starts and lasts
				send_pair(wme_pkg::BASE_W'($urandom_range(7)),
					wme_pkg::BASE_W'($urandom_range(7)),
					$urandom_range(99) < 20, $urandom_range(99) < 20);
				sent++;
			end else begin
				n = ($urandom_range(9) == 0) ? $urandom_range(150, 41) : $urandom_range(40, 1);
				run_attempt(n, $urandom_range(100, 50), -1);
				sent += n;
			end
		end
		// leave an attempt open across the next register write
		send_pair(wme_pkg::BASE_W'($urandom_range(3)), wme_pkg::BASE_W'($urandom_range(3)),
			1'b1, 1'b0);
		send_pair(wme_pkg::BASE_W'($urandom_range(7)), wme_pkg::BASE_W'($urandom_range(7)),
			1'b0, 1'b0);
	endtask

	initial begin
		int ws;
		int lim;
		int mrun;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at reset register values (window 16, limit 7, min run 3).
		// pair with no attempt open: dropped
		send_pair(3'd0, 3'd0, 1'b0, 1'b0);
		// start and last on one pair
		send_pair(3'd3, 3'd3, 1'b1, 1'b1);
		// three N-against-N pairs, then a qualifying run
		send_pair(3'd7, 3'd7, 1'b1, 1'b0);
		send_pair(3'd4, 3'd4, 1'b0, 1'b0);
		send_pair(3'd5, 3'd6, 1'b0, 1'b0);
		send_pair(3'd1, 3'd1, 1'b0, 1'b0);
		send_pair(3'd2, 3'd2, 1'b0, 1'b0);
		send_pair(3'd3, 3'd3, 1'b0, 1'b0);
		send_pair(3'd0, 3'd3, 1'b0, 1'b0);
		send_pair(3'd6, 3'd0, 1'b0, 1'b0);
		send_pair(3'd7, 3'd1, 1'b0, 1'b0);
		send_pair(3'd0, 3'd7, 1'b0, 1'b0);
		// eighth mismatch crosses the limit on the last pair
		send_pair(3'd1, 3'd2, 1'b0, 1'b1);
		// after the result: dropped until the next start
		send_pair(3'd2, 3'd2, 1'b0, 1'b1);
		// clean attempt that runs out of input
		send_pair(3'd0, 3'd0, 1'b1, 1'b0);
		send_pair(3'd1, 3'd1, 1'b0, 1'b0);
		send_pair(3'd2, 3'd2, 1'b0, 1'b1);
		// limit crossed mid-attempt, remainder dropped
		run_attempt(12, 0, -1);
		drain();

		// Random phases, one register setting each.
		for (int i = 0; i < N_SETS; i++) begin
			if (i < 8) begin
				ws = set_ws[i];
				lim = set_lim[i];
				mrun = set_run[i];
			end else begin
				ws = $urandom_range(127);
				lim = $urandom_range(127);
				mrun = $urandom_range(255);
			end
			write_reg(wme_pkg::REG_WINDOW_SIZE, ws, wme_pkg::WS_W);
			write_reg(wme_pkg::REG_MISMATCH_LIMIT, lim, wme_pkg::LIM_W);
			write_reg(wme_pkg::REG_MIN_RUN, mrun, wme_pkg::RUN_W);
			// one phase with no idling at all, made longer
			gaps_on = (i != 3);
			// long clean run: drive the run counter into saturation
			if (mrun >= 200)
				run_attempt(270, 100, 10);
			run_phase((i == 3) ? 5 * PHASE_ITEMS : PHASE_ITEMS);
			drain();
		end

		// Back-pressure: short attempts while the receiver holds off.
		write_reg(wme_pkg::REG_WINDOW_SIZE, 4, wme_pkg::WS_W);
		write_reg(wme_pkg::REG_MISMATCH_LIMIT, 1, wme_pkg::LIM_W);
		write_reg(wme_pkg::REG_MIN_RUN, 0, wme_pkg::RUN_W);
		gaps_on = 1'b1;
		hold_req = 1'b1;
		repeat (80)
			run_attempt($urandom_range(3, 1), 70, -1);
		drain();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
